### rtl/core/hmng_pkg.sv
// shared types and constants of the heightmap normal generator
`default_nettype none

package hmng_pkg;

  localparam int GRID_MAX_DEF = 1024;
  localparam int HEIGHT_W     = 16;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 16;
  localparam int LAST_W       = 10;
  localparam int STEP_W       = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_LAST   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_STEP = CFG_IDX_W'(1);

  localparam logic [LAST_W-1:0] GRID_LAST_RST = 10'd255;
  localparam logic [STEP_W-1:0] DSTEP_RST     = 16'd256;
  localparam logic [15:0]       ONE_Q14       = 16'd16384;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SQUARE,
    ST_ROOT,
    ST_DIV_INIT,
    ST_DIV,
    ST_OUT,
    ST_WRITE
  } hmng_state_t;

endpackage

`default_nettype wire

### rtl/core/hmng_ram.sv
// generic single write port ram with registered read
`default_nettype none

module hmng_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/core/heightmap_normal_generator_top.sv
// heightmap normal generator: line buffers, sequencer and shared bit-serial datapath
//
// Heights arrive in raster order over a square grid of (grid_last+1)^2 vertices; for each
// vertex the block emits the unit normal normalize(left-right, double_step, below-above) in
// Q1.14, one row and one column behind the input, with neighbors clamped at the borders.
// An item causes zero to four normals (four on the item that completes the grid). The block
// takes one item at a time and can be held by a stall on the output side. Its pace is set
// by one 64-bit subtractor shared by the 32-step square root and three 16-step restoring
// divides per normal (a zero vector skips both), and by the three reads of each normal's
// neighbors from the single-read-port line buffer memories. Writing grid_last restarts the
// grid at vertex (0, 0).
`default_nettype none

module heightmap_normal_generator_top #(
  parameter int GRID_MAX = hmng_pkg::GRID_MAX_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [15:0]               in_height,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [15:0]                    out_normal_x,
  output logic        [14:0]                    out_normal_y,
  output logic signed [15:0]                    out_normal_z,
  output logic        [9:0]                     out_column,
  output logic        [9:0]                     out_row,
  output logic                                  out_last_of_run,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [hmng_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hmng_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int ADDR_W = $clog2(GRID_MAX);

  hmng_pkg::hmng_state_t state_r, state_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [3:0]        need_r, need_nxt;
  logic [1:0]        j_r, j_nxt;
  logic              bank_r, bank_nxt;
  logic [ADDR_W-1:0] c_r, c_nxt, r_r, r_nxt;
  logic [9:0]        grid_last_r, grid_last_nxt;
  logic [15:0]       dstep_r, dstep_nxt;
  logic signed [15:0] cur_r, cur_nxt, p_r, p_nxt, pp_r, pp_nxt;
  logic [15:0]       opl_r, opl_nxt, opr_r, opr_nxt, opd_r, opd_nxt;
  logic signed [16:0] dx_r, dx_nxt, dz_r, dz_nxt;
  logic [33:0]       s_r, s_nxt;
  logic [61:0]       v_r, v_nxt;
  logic [63:0]       res_r, res_nxt;
  logic [32:0]       rem_r, rem_nxt;
  logic [15:0]       nlo_r, nlo_nxt;
  logic [15:0]       q_r, q_nxt;
  logic signed [15:0] nx_r, nx_nxt, nz_r, nz_nxt;
  logic [14:0]       ny_r, ny_nxt;

  logic [ADDR_W-1:0] last, lastm1, x, c_eff, r_eff, rd_addr, wr_addr;
  logic [15:0]       rd0, rd1, rd_new, rd_old, rd_down, wr_data;
  logic              we0, we1, wr_en;
  logic signed [15:0] left_v, right_v, up_v;
  logic [16:0]       abs_dx, abs_dz, sq_op, div_a;
  logic [33:0]       prod;
  logic [63:0]       sub_a, sub_b, bitv;
  logic [64:0]       diff;
  logic              geq;
  logic [45:0]       num;
  logic [32:0]       t;
  logic [15:0]       q_sat;
  logic [31:0]       root;
  logic [2:0]        nk, first_k;
  logic [3:0]        need_in;

  // lowest set bit of v at or above from, 4 when none
  function automatic logic [2:0] next_idx(input logic [3:0] v, input logic [2:0] from);
    logic [2:0] idx;
    idx = 3'd4;
    for (int i = 3; i >= 0; i--) begin
      if (v[i] && (3'(i) >= from)) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

  always_comb begin
    if (int'(grid_last_r) > GRID_MAX - 1) begin
      last = ADDR_W'(GRID_MAX - 1);
    end else if (grid_last_r == 10'd0) begin
      last = ADDR_W'(1);
    end else begin
      last = ADDR_W'(grid_last_r);
    end
  end

  assign lastm1 = last - ADDR_W'(1);
  assign x      = c_r - ADDR_W'(1);

  // line buffers: the newer row sits in ram1 when bank_r is set
  hmng_ram #(.WIDTH(16), .DEPTH(GRID_MAX)) u_ram0 (
    .clk(clk), .wr_en(we0), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd0)
  );

  hmng_ram #(.WIDTH(16), .DEPTH(GRID_MAX)) u_ram1 (
    .clk(clk), .wr_en(we1), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd1)
  );

  assign rd_new  = bank_r ? rd1 : rd0;
  assign rd_old  = bank_r ? rd0 : rd1;
  // second row reuses the first row as its clamped upper neighbor
  assign rd_down = (k_r[1] || (r_r == ADDR_W'(1))) ? rd_new : rd_old;

  always_comb begin
    case (cnt_r)
      5'd0:    rd_addr = (k_r == 2'd0) ? ((x == '0) ? '0 : x - ADDR_W'(1)) : lastm1;
      5'd1:    rd_addr = (k_r == 2'd0) ? c_r : last;
      default: rd_addr = k_r[0] ? last : x;
    endcase
  end

  // writes always go to the older row
  assign we0 = wr_en & bank_r;
  assign we1 = wr_en & ~bank_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = x;
    wr_data = p_r;
    if (state_r == hmng_pkg::ST_WRITE) begin
      if (cnt_r == 5'd0) begin
        wr_en = (c_r != '0);
      end else begin
        wr_en   = (c_r == last);
        wr_addr = last;
        wr_data = cur_r;
      end
    end
  end

  // neighbor selection per result slot
  always_comb begin
    if (k_r[1]) begin
      left_v  = ((k_r == 2'd2) && (x != '0)) ? pp_r : p_r;
      right_v = cur_r;
    end else begin
      left_v  = opl_r;
      right_v = opr_r;
    end
    up_v = k_r[0] ? cur_r : p_r;
  end

  assign abs_dx = dx_r[16] ? 17'(-dx_r) : 17'(dx_r);
  assign abs_dz = dz_r[16] ? 17'(-dz_r) : 17'(dz_r);

  always_comb begin
    case (cnt_r)
      5'd1:    sq_op = abs_dx;
      5'd2:    sq_op = 17'(dstep_r);
      default: sq_op = abs_dz;
    endcase
  end

  assign prod = 34'(sq_op) * 34'(sq_op);

  always_comb begin
    case (j_r)
      2'd0:    div_a = abs_dx;
      2'd1:    div_a = 17'(dstep_r);
      default: div_a = abs_dz;
    endcase
  end

  assign root = res_r[31:0];
  assign num  = (46'(div_a) << 28) + 46'(root[31:1]);
  assign t    = {rem_r[31:0], nlo_r[15]};
  assign bitv = 64'(1) << {cnt_r, 1'b0};

  // shared subtractor: root step or divide step
  always_comb begin
    if (state_r == hmng_pkg::ST_ROOT) begin
      sub_a = 64'(v_r);
      sub_b = res_r + bitv;
    end else begin
      sub_a = 64'(t);
      sub_b = 64'(root);
    end
  end

  assign diff  = {1'b0, sub_a} - {1'b0, sub_b};
  assign geq   = ~diff[64];
  assign q_sat = ({q_r[14:0], geq} > hmng_pkg::ONE_Q14) ? hmng_pkg::ONE_Q14
                                                        : {q_r[14:0], geq};

  assign c_eff   = ((c_r > last) || (r_r > last)) ? '0 : c_r;
  assign r_eff   = ((c_r > last) || (r_r > last)) ? '0 : r_r;
  assign need_in = {(r_eff == last) && (c_eff == last),
                    (r_eff == last) && (c_eff != '0),
                    (r_eff != '0) && (c_eff == last),
                    (r_eff != '0) && (c_eff != '0)};
  assign nk      = next_idx(need_r, {1'b0, k_r} + 3'd1);
  assign first_k = next_idx(need_in, 3'd0);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    need_nxt      = need_r;
    j_nxt         = j_r;
    bank_nxt      = bank_r;
    c_nxt         = c_r;
    r_nxt         = r_r;
    grid_last_nxt = grid_last_r;
    dstep_nxt     = dstep_r;
    cur_nxt       = cur_r;
    p_nxt         = p_r;
    pp_nxt        = pp_r;
    opl_nxt       = opl_r;
    opr_nxt       = opr_r;
    opd_nxt       = opd_r;
    dx_nxt        = dx_r;
    dz_nxt        = dz_r;
    s_nxt         = s_r;
    v_nxt         = v_r;
    res_nxt       = res_r;
    rem_nxt       = rem_r;
    nlo_nxt       = nlo_r;
    q_nxt         = q_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    nz_nxt        = nz_r;

    case (state_r)
      hmng_pkg::ST_IDLE: begin
        if (in_valid) begin
          cur_nxt  = in_height;
          c_nxt    = c_eff;
          r_nxt    = r_eff;
          need_nxt = need_in;
          cnt_nxt  = 5'd0;
          if (need_in == 4'd0) begin
            state_nxt = hmng_pkg::ST_WRITE;
          end else begin
            k_nxt     = first_k[1:0];
            state_nxt = hmng_pkg::ST_FETCH;
          end
        end
      end
      hmng_pkg::ST_FETCH: begin
        case (cnt_r)
          5'd1:    opl_nxt = rd_new;
          5'd2:    opr_nxt = rd_new;
          5'd3:    opd_nxt = rd_down;
          default: ;
        endcase
        if (cnt_r == 5'd3) begin
          cnt_nxt   = 5'd0;
          state_nxt = hmng_pkg::ST_SQUARE;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      hmng_pkg::ST_SQUARE: begin
        cnt_nxt = cnt_r + 5'd1;
        case (cnt_r)
          5'd0: begin
            dx_nxt = {left_v[15], left_v} - {right_v[15], right_v};
            dz_nxt = {opd_r[15], opd_r} - {up_v[15], up_v};
            s_nxt  = '0;
          end
          5'd4: begin
            if (s_r == '0) begin
              // zero vector points straight up
              nx_nxt    = '0;
              ny_nxt    = 15'(hmng_pkg::ONE_Q14);
              nz_nxt    = '0;
              state_nxt = hmng_pkg::ST_OUT;
            end else begin
              v_nxt     = {s_r, 28'd0};
              res_nxt   = '0;
              cnt_nxt   = 5'd31;
              state_nxt = hmng_pkg::ST_ROOT;
            end
          end
          default: s_nxt = s_r + prod;
        endcase
      end
      hmng_pkg::ST_ROOT: begin
        if (geq) begin
          v_nxt   = diff[61:0];
          res_nxt = (res_r >> 1) + bitv;
        end else begin
          res_nxt = res_r >> 1;
        end
        if (cnt_r == 5'd0) begin
          j_nxt     = 2'd0;
          state_nxt = hmng_pkg::ST_DIV_INIT;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      hmng_pkg::ST_DIV_INIT: begin
        // the top part of the numerator is already below the divisor
        rem_nxt   = 33'(num[45:16]);
        nlo_nxt   = num[15:0];
        q_nxt     = '0;
        cnt_nxt   = 5'd15;
        state_nxt = hmng_pkg::ST_DIV;
      end
      hmng_pkg::ST_DIV: begin
        rem_nxt = geq ? diff[32:0] : t;
        nlo_nxt = {nlo_r[14:0], 1'b0};
        q_nxt   = {q_r[14:0], geq};
        if (cnt_r == 5'd0) begin
          case (j_r)
            2'd0:    nx_nxt = dx_r[16] ? -$signed(q_sat) : $signed(q_sat);
            2'd1:    ny_nxt = q_sat[14:0];
            default: nz_nxt = dz_r[16] ? -$signed(q_sat) : $signed(q_sat);
          endcase
          if (j_r == 2'd2) begin
            state_nxt = hmng_pkg::ST_OUT;
          end else begin
            j_nxt     = j_r + 2'd1;
            state_nxt = hmng_pkg::ST_DIV_INIT;
          end
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      hmng_pkg::ST_OUT: begin
        if (out_ready) begin
          cnt_nxt = 5'd0;
          if (nk == 3'd4) begin
            state_nxt = hmng_pkg::ST_WRITE;
          end else begin
            k_nxt     = nk[1:0];
            state_nxt = hmng_pkg::ST_FETCH;
          end
        end
      end
      hmng_pkg::ST_WRITE: begin
        if (cnt_r == 5'd0) begin
          cnt_nxt = 5'd1;
        end else begin
          pp_nxt = p_r;
          p_nxt  = cur_r;
          if (c_r == last) begin
            bank_nxt = ~bank_r;
            c_nxt    = '0;
            r_nxt    = (r_r == last) ? '0 : r_r + ADDR_W'(1);
          end else begin
            c_nxt = c_r + ADDR_W'(1);
          end
          state_nxt = hmng_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hmng_pkg::ST_IDLE;
    endcase

    if (cfg_valid) begin
      case (cfg_index)
        hmng_pkg::REG_GRID_LAST: begin
          grid_last_nxt = cfg_data[9:0];
          c_nxt         = '0;
          r_nxt         = '0;
        end
        hmng_pkg::REG_DOUBLE_STEP: dstep_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hmng_pkg::ST_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      need_r      <= '0;
      j_r         <= '0;
      bank_r      <= 1'b0;
      c_r         <= '0;
      r_r         <= '0;
      grid_last_r <= hmng_pkg::GRID_LAST_RST;
      dstep_r     <= hmng_pkg::DSTEP_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      need_r      <= need_nxt;
      j_r         <= j_nxt;
      bank_r      <= bank_nxt;
      c_r         <= c_nxt;
      r_r         <= r_nxt;
      grid_last_r <= grid_last_nxt;
      dstep_r     <= dstep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    p_r   <= p_nxt;
    pp_r  <= pp_nxt;
    opl_r <= opl_nxt;
    opr_r <= opr_nxt;
    opd_r <= opd_nxt;
    dx_r  <= dx_nxt;
    dz_r  <= dz_nxt;
    s_r   <= s_nxt;
    v_r   <= v_nxt;
    res_r <= res_nxt;
    rem_r <= rem_nxt;
    nlo_r <= nlo_nxt;
    q_r   <= q_nxt;
    nx_r  <= nx_nxt;
    ny_r  <= ny_nxt;
    nz_r  <= nz_nxt;
  end

  assign in_ready        = (state_r == hmng_pkg::ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = (state_r == hmng_pkg::ST_OUT);
  assign out_normal_x    = nx_r;
  assign out_normal_y    = ny_r;
  assign out_normal_z    = nz_r;
  assign out_column      = (k_r[0] == 1'b0) ? 10'(x) : 10'(last);
  assign out_row         = k_r[1] ? 10'(last) : 10'(r_r - ADDR_W'(1));
  assign out_last_of_run = (nk == 3'd4);

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input taken while a result is pending");

  a_last_then_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_of_run) |=> (state_r == hmng_pkg::ST_WRITE))
    else $error("line buffer update skipped after final result");

  a_pos_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != hmng_pkg::ST_IDLE) |-> ((c_r <= last) && (r_r <= last)))
    else $error("vertex position outside grid");
`endif

endmodule

`default_nettype wire
